// ----- rtl/core/mpst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpst_pkg: shared types and constants of the matrix product segment tree
// Matrix word type, field widths, reduction constants and register map.
// ----------------------------------------------------------------------------
package mpst_pkg;

	localparam int unsigned LEAVES_DEF   = 1024;
	localparam int unsigned INDEX_W      = 10;
	localparam int unsigned ENTRY_W      = 16;
	localparam int unsigned MOD_W        = 17;
	localparam int unsigned RECIP_W      = 34;
	localparam int unsigned RED_SHIFT    = 33;
	localparam int unsigned PADDR_W      = 3;
	localparam int unsigned PDATA_W      = 32;

	localparam logic [ENTRY_W-1:0] MODULUS_RESET = 16'hFFFF;

	// register indexes (byte address / 4)
	localparam logic REG_MODULUS = 1'b0;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic [ENTRY_W-1:0] tl;
		logic [ENTRY_W-1:0] tr;
		logic [ENTRY_W-1:0] bl;
		logic [ENTRY_W-1:0] br;
	} mat_t;

	localparam mat_t IDENT_MAT = '{tl: 16'd1, tr: 16'd0, bl: 16'd0, br: 16'd1};
	localparam mat_t ZERO_MAT  = '{tl: 16'd0, tr: 16'd0, bl: 16'd0, br: 16'd0};

endpackage

// ----- rtl/core/mpst_matmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpst_matmul: pipelined 2x2 modular matrix multiply
// Four lanes, one per result entry. Products, sum, Barrett quotient with a
// precomputed reciprocal floor(2^33/m), then two conditional subtracts.
// Takes one matrix pair per cycle.
// ----------------------------------------------------------------------------
module mpst_matmul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  mpst_pkg::mat_t               a,
	input  mpst_pkg::mat_t               b,
	input  logic [mpst_pkg::MOD_W-1:0]   modulus,
	input  logic [mpst_pkg::RECIP_W-1:0] recip,
	output logic                         out_valid,
	output mpst_pkg::mat_t               z
);
	import mpst_pkg::*;

	localparam int unsigned XW = 2 * ENTRY_W + 1;
	localparam int unsigned HW = RECIP_W / 2;
	localparam int unsigned MW = XW + HW;
	localparam int unsigned SW = MW + HW + 1;
	localparam int unsigned RW = MOD_W + 1;

	logic [ENTRY_W-1:0] ae [4];
	logic [ENTRY_W-1:0] be [4];
	logic [2*ENTRY_W-1:0] pa_s1 [4];
	logic [2*ENTRY_W-1:0] pb_s1 [4];
	logic [XW-1:0] x_s2 [4];
	logic [XW-1:0] x_s3 [4];
	logic [XW-1:0] x_s4 [4];
	logic [XW-1:0] x_s5 [4];
	logic [MW-1:0] tlo_s3 [4];
	logic [MW-1:0] thi_s3 [4];
	logic [SW-1:0] sum [4];
	logic [MW-1:0] qm [4];
	logic [XW-1:0] q_s4 [4];
	logic [XW-1:0] qm_s5 [4];
	logic [XW-1:0] diff [4];
	logic [RW-1:0] r_s6 [4];
	logic [RW-1:0] r_s7 [4];
	logic [ENTRY_W-1:0] z_s8 [4];
	logic [RW-1:0] m_ext;
	logic [7:0] v_q;

	assign {ae[0], ae[1], ae[2], ae[3]} = a;
	assign {be[0], be[1], be[2], be[3]} = b;
	assign m_ext = {1'b0, modulus};

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sum[k]  = {thi_s3[k], {HW{1'b0}}} + SW'(tlo_s3[k]);
			qm[k]   = MW'(q_s4[k]) * MW'(modulus);
			diff[k] = x_s5[k] - qm_s5[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			// lane k is row k/2, column k%2
			pa_s1[k]  <= ae[(k / 2) * 2] * be[k % 2];
			pb_s1[k]  <= ae[(k / 2) * 2 + 1] * be[2 + (k % 2)];
			x_s2[k]   <= XW'(pa_s1[k]) + XW'(pb_s1[k]);
			tlo_s3[k] <= MW'(x_s2[k]) * MW'(recip[HW-1:0]);
			thi_s3[k] <= MW'(x_s2[k]) * MW'(recip[RECIP_W-1:HW]);
			x_s3[k]   <= x_s2[k];
			q_s4[k]   <= sum[k][RED_SHIFT+XW-1:RED_SHIFT];
			x_s4[k]   <= x_s3[k];
			qm_s5[k]  <= qm[k][XW-1:0];
			x_s5[k]   <= x_s4[k];
			r_s6[k]   <= diff[k][RW-1:0];
			r_s7[k]   <= (r_s6[k] >= m_ext) ? r_s6[k] - m_ext : r_s6[k];
			z_s8[k]   <= (r_s7[k] >= m_ext) ? ENTRY_W'(r_s7[k] - m_ext) : ENTRY_W'(r_s7[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[6:0], in_valid};
		end
	end

	assign out_valid = v_q[7];
	assign z = {z_s8[0], z_s8[1], z_s8[2], z_s8[3]};

endmodule

// ----- rtl/core/matrix_product_segment_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_product_segment_tree: segment tree of 2x2 matrices modulo m
// Node store in one synchronous RAM, walked by a sequencer that feeds a
// shared pipelined modular matrix multiplier.
// ----------------------------------------------------------------------------
// One item at a time; busy is high while an item is in work. After reset a
// clearing pass writes the identity to all 2*2^ceil(log2(LEAVES)) nodes,
// and each modulus write, like reset, starts a reciprocal computation; busy
// covers both. A write walks down to its leaf, reduces the word and then
// recomputes each ancestor from a RAM read of its two children and a pass
// through the multiplier. A query walks the tree in order visiting at most
// about 4*log2(LEAVES) nodes, and multiplies every node that lies wholly in
// the range (at most about 2*log2(LEAVES)) into its product. The result
// appears on the prod ports as done goes high for one cycle, and is held
// until the next query ends; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module matrix_product_segment_tree #(
	parameter int unsigned LEAVES = mpst_pkg::LEAVES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mpst_pkg::PADDR_W-1:0] paddr,
	input  logic [mpst_pkg::PDATA_W-1:0] pwdata,
	output logic [mpst_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  logic                         operation,
	input  logic [mpst_pkg::INDEX_W-1:0] leaf_index,
	input  logic [mpst_pkg::INDEX_W-1:0] range_low,
	input  logic [mpst_pkg::INDEX_W-1:0] range_high,
	input  logic [mpst_pkg::ENTRY_W-1:0] top_left,
	input  logic [mpst_pkg::ENTRY_W-1:0] top_right,
	input  logic [mpst_pkg::ENTRY_W-1:0] bottom_left,
	input  logic [mpst_pkg::ENTRY_W-1:0] bottom_right,
	output logic                         done,
	output logic [mpst_pkg::ENTRY_W-1:0] prod_top_left,
	output logic [mpst_pkg::ENTRY_W-1:0] prod_top_right,
	output logic [mpst_pkg::ENTRY_W-1:0] prod_bottom_left,
	output logic [mpst_pkg::ENTRY_W-1:0] prod_bottom_right
);
	import mpst_pkg::*;

	localparam int unsigned NW = $clog2(LEAVES) + 1;
	localparam int unsigned NODE_DEPTH = 1 << NW;
	localparam int unsigned CW = (NW > INDEX_W) ? NW : INDEX_W;
	localparam int unsigned DW = (NW > 1) ? $clog2(NW) : 1;
	localparam logic [CW-1:0] LAST = CW'(LEAVES - 1);
	localparam int unsigned CNT_W = $clog2(RED_SHIFT + 1);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_W_DESC,
		ST_W_RED,
		ST_W_RD,
		ST_W_MUL,
		ST_W_WAIT,
		ST_Q_VISIT,
		ST_Q_MUL,
		ST_Q_WAIT,
		ST_Q_NEXT,
		ST_Q_DONE
	} state_t;

	state_t state_q;

	mat_t node_mem [NODE_DEPTH];
	mat_t rd0_q, rd1_q;
	logic mem_we;
	logic [NW-1:0] mem_waddr, raddr0, raddr1;
	mat_t mem_wdata;

	logic [NW-1:0] node_q, clr_q;
	logic [CW-1:0] lt_q, rt_q, lo_q, hi_q, leaf_q, md;
	logic [CW-1:0] lo_in, hi_in;
	logic [DW-1:0] depth_q;
	logic [CW-1:0] stk_q [NW];
	mat_t val_q, acc_q;
	logic acc_used_q;
	logic done_q;
	mat_t prod_q;

	logic [ENTRY_W-1:0] modulus_q;
	logic [MOD_W-1:0] m_eff;
	logic [RECIP_W-1:0] recip_q;
	logic [MOD_W-1:0] div_rem_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic div_busy_q;
	logic [MOD_W:0] rem_sh;
	logic div_ge;

	logic cfg_wr, accept;
	logic mm_valid, mm_out_valid;
	mat_t mm_a, mm_b, mm_z;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[PADDR_W-1] == REG_MODULUS) ?
		PDATA_W'(modulus_q) : '0;
	assign m_eff = (modulus_q == '0) ? MOD_W'(1 << ENTRY_W) : {1'b0, modulus_q};

	assign busy = (state_q != ST_IDLE) || div_busy_q || cfg_wr;
	assign accept = start && !busy;

	// reciprocal floor(2^33 / m), one quotient bit a cycle
	assign rem_sh = {div_rem_q, (div_cnt_q == CNT_W'(RED_SHIFT))};
	assign div_ge = rem_sh >= {1'b0, m_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= MODULUS_RESET;
			div_busy_q <= 1'b1;
			div_cnt_q  <= CNT_W'(RED_SHIFT);
			div_rem_q  <= '0;
			recip_q    <= '0;
		end else if (cfg_wr && (paddr[PADDR_W-1] == REG_MODULUS)) begin
			modulus_q  <= pwdata[ENTRY_W-1:0];
			div_busy_q <= 1'b1;
			div_cnt_q  <= CNT_W'(RED_SHIFT);
			div_rem_q  <= '0;
			recip_q    <= '0;
		end else if (div_busy_q) begin
			div_rem_q <= div_ge ? MOD_W'(rem_sh - {1'b0, m_eff}) : MOD_W'(rem_sh);
			recip_q   <= {recip_q[RECIP_W-2:0], div_ge};
			if (div_cnt_q == '0) begin
				div_busy_q <= 1'b0;
			end else begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
		end
	end

	// node store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			node_mem[mem_waddr] <= mem_wdata;
		end
		rd0_q <= node_mem[raddr0];
		rd1_q <= node_mem[raddr1];
	end

	mpst_matmul u_matmul (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mm_valid),
		.a        (mm_a),
		.b        (mm_b),
		.modulus  (m_eff),
		.recip    (recip_q),
		.out_valid(mm_out_valid),
		.z        (mm_z)
	);

	assign md = lt_q + ((rt_q - lt_q) >> 1);
	assign lo_in = CW'(range_low);
	assign hi_in = (CW'(range_high) > LAST) ? LAST : CW'(range_high);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = node_q;
		mem_wdata = mm_z;
		raddr0    = node_q;
		raddr1    = node_q;
		mm_valid  = 1'b0;
		mm_a      = acc_q;
		mm_b      = rd0_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = IDENT_MAT;
			end
			ST_W_RED: begin
				mm_valid = 1'b1;
				mm_a     = val_q;
				mm_b     = IDENT_MAT;
			end
			ST_W_RD: begin
				raddr0 = node_q << 1;
				raddr1 = (node_q << 1) | NW'(1);
			end
			ST_W_MUL: begin
				mm_valid = 1'b1;
				mm_a     = rd0_q;
				mm_b     = rd1_q;
			end
			ST_W_WAIT: begin
				mem_we = mm_out_valid;
			end
			ST_Q_MUL: begin
				mm_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			node_q     <= NW'(1);
			lt_q       <= '0;
			rt_q       <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			leaf_q     <= '0;
			depth_q    <= '0;
			for (int i = 0; i < NW; i++) stk_q[i] <= '0;
			val_q      <= IDENT_MAT;
			acc_q      <= IDENT_MAT;
			acc_used_q <= 1'b0;
			done_q     <= 1'b0;
			prod_q     <= ZERO_MAT;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == NW'(NODE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						node_q  <= NW'(1);
						lt_q    <= '0;
						rt_q    <= LAST;
						depth_q <= '0;
						stk_q[0] <= LAST;
						if (operation == OP_WRITE) begin
							leaf_q <= CW'(leaf_index);
							val_q  <= '{tl: top_left, tr: top_right,
								bl: bottom_left, br: bottom_right};
							// leaf past the end: drop the word
							if (32'(leaf_index) < 32'(LEAVES)) begin
								state_q <= ST_W_DESC;
							end
						end else begin
							lo_q       <= lo_in;
							hi_q       <= hi_in;
							acc_q      <= IDENT_MAT;
							acc_used_q <= 1'b0;
							state_q    <= (lo_in > hi_in) ? ST_Q_DONE : ST_Q_VISIT;
						end
					end
				end
				ST_W_DESC: begin
					if (lt_q == rt_q) begin
						state_q <= ST_W_RED;
					end else if (leaf_q <= md) begin
						node_q <= node_q << 1;
						rt_q   <= md;
					end else begin
						node_q <= (node_q << 1) | NW'(1);
						lt_q   <= md + CW'(1);
					end
				end
				ST_W_RED: begin
					state_q <= ST_W_WAIT;
				end
				ST_W_RD: begin
					state_q <= ST_W_MUL;
				end
				ST_W_MUL: begin
					state_q <= ST_W_WAIT;
				end
				ST_W_WAIT: begin
					if (mm_out_valid) begin
						if (node_q == NW'(1)) begin
							state_q <= ST_IDLE;
						end else begin
							node_q  <= node_q >> 1;
							state_q <= ST_W_RD;
						end
					end
				end
				ST_Q_VISIT: begin
					if (rt_q < lo_q) begin
						state_q <= ST_Q_NEXT;
					end else if ((lo_q <= lt_q) && (rt_q <= hi_q)) begin
						// node read is on its way; fold it in next
						state_q <= ST_Q_MUL;
					end else begin
						node_q  <= node_q << 1;
						rt_q    <= md;
						depth_q <= depth_q + 1'b1;
						stk_q[DW'(depth_q + 1'b1)] <= md;
					end
				end
				ST_Q_MUL: begin
					state_q <= ST_Q_WAIT;
				end
				ST_Q_WAIT: begin
					if (mm_out_valid) begin
						acc_q      <= mm_z;
						acc_used_q <= 1'b1;
						state_q    <= (rt_q >= hi_q) ? ST_Q_DONE : ST_Q_NEXT;
					end
				end
				ST_Q_NEXT: begin
					// climb out of right children, then step to the right sibling
					if (node_q[0]) begin
						node_q  <= node_q >> 1;
						depth_q <= depth_q - 1'b1;
					end else begin
						node_q         <= node_q | NW'(1);
						lt_q           <= rt_q + CW'(1);
						rt_q           <= stk_q[DW'(depth_q - 1'b1)];
						stk_q[depth_q] <= stk_q[DW'(depth_q - 1'b1)];
						state_q        <= ST_Q_VISIT;
					end
				end
				ST_Q_DONE: begin
					if (acc_used_q) begin
						prod_q <= acc_q;
					end else begin
						prod_q <= (m_eff == MOD_W'(1)) ? ZERO_MAT : IDENT_MAT;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done              = done_q;
	assign prod_top_left     = prod_q.tl;
	assign prod_top_right    = prod_q.tr;
	assign prod_bottom_left  = prod_q.bl;
	assign prod_bottom_right = prod_q.br;

endmodule
